// ===== rtl/core/md4_pkg.sv =====
// MD4 digest package: widths, constants, block types and round functions.
package md4_pkg;

  localparam int WORD_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int NUM_WORDS = 16;
  localparam int CV_WORDS  = 4;
  localparam int CNT_W     = 61;

  // Initial chaining words
  localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
  localparam logic [WORD_W-1:0] IV1 = 32'hefcdab89;
  localparam logic [WORD_W-1:0] IV2 = 32'h98badcfe;
  localparam logic [WORD_W-1:0] IV3 = 32'h10325476;

  // Round constants for the second and third rounds
  localparam logic [WORD_W-1:0] K2 = 32'h5a827999;
  localparam logic [WORD_W-1:0] K3 = 32'h6ed9eba1;

  localparam logic [BYTE_W-1:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0]        LAST_RND  = 6'd47;
  localparam logic [5:0]        LAST_POS  = 6'd63;
  localparam logic [1:0]        LAST_IDX  = 2'd3;
  localparam logic [1:0]        PH_R1     = 2'd0;
  localparam logic [1:0]        PH_R2     = 2'd1;
  localparam logic [2:0]        LEN_SLOT  = 3'b111;

  typedef logic [WORD_W-1:0] md4_word_t;

  // One 64-byte block in flight from front to back
  typedef struct packed {
    logic [NUM_WORDS-1:0][WORD_W-1:0] words;
    logic                             last_blk;
  } md4_blk_t;

  typedef struct packed {
    logic     valid;
    md4_blk_t blk;
  } md4_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } md4_qstat_t;

  // Rotate left by s
  function automatic md4_word_t md4_rol(input md4_word_t x, input logic [4:0] s);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x} << s;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

  // Message word used by round step rnd
  function automatic logic [3:0] md4_word_idx(input logic [5:0] rnd);
    logic [3:0] j;
    logic [3:0] idx;
    j = rnd[3:0];
    case (rnd[5:4])
      PH_R1:   idx = j;
      PH_R2:   idx = {j[1:0], j[3:2]};
      default: idx = {j[0], j[1], j[2], j[3]};
    endcase
    return idx;
  endfunction

  // Rotation amount of round step rnd
  function automatic logic [4:0] md4_rot(input logic [5:0] rnd);
    logic [4:0] s;
    case (rnd[5:4])
      PH_R1: begin
        case (rnd[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd7;
          2'd2:    s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      PH_R2: begin
        case (rnd[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd5;
          2'd2:    s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        case (rnd[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd9;
          2'd2:    s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
    return s;
  endfunction

  // New b word of one round step
  function automatic md4_word_t md4_step(input md4_word_t a, input md4_word_t b,
                                         input md4_word_t c, input md4_word_t d,
                                         input md4_word_t w, input logic [5:0] rnd);
    md4_word_t f;
    md4_word_t k;
    case (rnd[5:4])
      PH_R1: begin
        f = d ^ (b & (c ^ d));
        k = '0;
      end
      PH_R2: begin
        f = (b & (c | d)) | (c & d);
        k = K2;
      end
      default: begin
        f = b ^ c ^ d;
        k = K3;
      end
    endcase
    return md4_rol(a + f + w + k, md4_rot(rnd));
  endfunction

endpackage

// ===== rtl/core/md4_in_if.sv =====
// Byte input channel: valid/ready handshake with message byte payload.
interface md4_in_if import md4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_present;
  logic              last_byte;

  modport source(output valid, data_byte, byte_present, last_byte, input ready);
  modport sink(input valid, data_byte, byte_present, last_byte, output ready);
endinterface

// ===== rtl/core/md4_out_if.sv =====
// Digest output channel: valid/ready handshake with one chaining word per transfer.
interface md4_out_if import md4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] digest_word;
  logic [1:0]        word_index;
  logic              last_word;

  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/core/md4_message_digest.sv =====
// MD4 digest top level: byte front end, block queue and compression back end.
//
//  channel   dir  handshake        word carries
//  in_chan   in   valid / ready    data_byte, byte_present, last_byte
//  out_chan  out  valid / ready    digest_word, word_index, last_word
//
// The front takes one word per cycle while it is not padding and the block
// queue has room; a byte that completes a block pushes it in the same cycle.
// The back handles one block at a time: load, 48 round steps, fold.
// After a last_byte word the front pushes one or two padding blocks; the
// digest then leaves as four words, one per accepted transfer. Reset is
// synchronous, active low; a stalled output holds the back and, once the queue fills, the front.
module md4_message_digest import md4_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  md4_in_if.sink      in_chan,
  md4_out_if.source   out_chan
);

  md4_push_t  q_push;
  md4_qstat_t q_stat;
  md4_blk_t   q_head;
  logic       q_pop;

  md4_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_stat  (q_stat),
    .q_push  (q_push)
  );

  md4_blk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  md4_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

// ===== rtl/core/md4_front.sv =====
// Front end: gathers bytes into blocks, counts length and builds the padding blocks.
module md4_front import md4_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  md4_in_if.sink       in_chan,
  input  md4_qstat_t   q_stat,
  output md4_push_t    q_push
);

  typedef enum logic [2:0] {
    F_ACC = 3'b001,
    F_PAD = 3'b010,
    F_LEN = 3'b100
  } md4_fstate_t;

  md4_fstate_t                      state_r, state_nxt;
  logic [NUM_WORDS-1:0][WORD_W-1:0] blk_r, blk_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;

  logic [5:0]                       pos;
  logic [3:0]                       wi;
  logic [1:0]                       lane;
  logic                             accept;
  md4_word_t                        byte_word;
  md4_word_t                        new_word;
  logic [NUM_WORDS-1:0][WORD_W-1:0] merged;
  logic [NUM_WORDS-1:0][WORD_W-1:0] padded;
  md4_word_t                        len_lo;
  md4_word_t                        len_hi;
  logic                             two_blk;

  assign pos       = cnt_r[5:0];
  assign wi        = pos[5:2];
  assign lane      = pos[1:0];
  assign len_lo    = {cnt_r[28:0], 3'b000};
  assign len_hi    = cnt_r[CNT_W-1:29];
  assign two_blk   = (pos[5:3] == LEN_SLOT);

  assign in_chan.ready = (state_r == F_ACC) && !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;

  // Merge the incoming byte into its lane; lane zero starts a fresh word
  assign byte_word = {{(WORD_W-BYTE_W){1'b0}}, in_chan.data_byte};
  assign new_word  = (lane == 2'd0) ? byte_word
                                    : (blk_r[wi] | (byte_word << {lane, 3'b000}));

  always_comb begin
    merged     = blk_r;
    merged[wi] = new_word;
  end

  // Keep bytes below the end mark, place the pad byte, zero the rest
  always_comb begin
    logic [5:0] bidx;
    padded = '0;
    for (int k = 0; k < NUM_WORDS; k++) begin
      for (int l = 0; l < 4; l++) begin
        bidx = 6'(k * 4 + l);
        if (bidx < pos) begin
          padded[k][8*l +: 8] = blk_r[k][8*l +: 8];
        end else if (bidx == pos) begin
          padded[k][8*l +: 8] = PAD_BYTE;
        end
      end
    end
  end

  // Sequence byte intake and padding pushes
  always_comb begin
    state_nxt = state_r;
    blk_nxt   = blk_r;
    cnt_nxt   = cnt_r;
    q_push    = '0;
    q_push.blk.words = merged;
    case (state_r)
      F_ACC: begin
        if (accept) begin
          if (in_chan.byte_present) begin
            blk_nxt = merged;
            cnt_nxt = cnt_r + CNT_W'(1);
            if (pos == LAST_POS) begin
              q_push.valid = 1'b1;
            end
          end
          if (in_chan.last_byte) begin
            state_nxt = F_PAD;
          end
        end
      end
      F_PAD: begin
        q_push.blk.words = padded;
        if (!two_blk) begin
          q_push.blk.words[NUM_WORDS-2] = len_lo;
          q_push.blk.words[NUM_WORDS-1] = len_hi;
          q_push.blk.last_blk           = 1'b1;
        end
        if (!q_stat.full) begin
          q_push.valid = 1'b1;
          if (two_blk) begin
            state_nxt = F_LEN;
          end else begin
            cnt_nxt   = '0;
            state_nxt = F_ACC;
          end
        end
      end
      F_LEN: begin
        q_push.blk.words              = '0;
        q_push.blk.words[NUM_WORDS-2] = len_lo;
        q_push.blk.words[NUM_WORDS-1] = len_hi;
        q_push.blk.last_blk           = 1'b1;
        if (!q_stat.full) begin
          q_push.valid = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = F_ACC;
        end
      end
      default: begin
        state_nxt = F_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_ACC;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Block words need no reset
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

// ===== rtl/core/md4_blk_queue.sv =====
// Block queue between front and back: up to DEPTH full blocks in flight.
module md4_blk_queue import md4_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  md4_push_t  push,
  input  logic       pop,
  output md4_blk_t   head,
  output md4_qstat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  md4_blk_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push.valid, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed block
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.blk;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (!stat.full || pop))
    else $error("block pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("block popped from empty queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

// ===== rtl/core/md4_back.sv =====
// Back end: 48-step compression, one step per cycle, and digest word output.
module md4_back import md4_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  md4_blk_t     head,
  input  md4_qstat_t   q_stat,
  output logic         q_pop,
  md4_out_if.source    out_chan
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_RND  = 4'b0010,
    B_ADD  = 4'b0100,
    B_OUT  = 4'b1000
  } md4_bstate_t;

  md4_bstate_t                     state_r, state_nxt;
  logic [CV_WORDS-1:0][WORD_W-1:0] cv_r, cv_nxt;
  md4_word_t                       a_r, b_r, c_r, d_r;
  md4_word_t                       a_nxt, b_nxt, c_nxt, d_nxt;
  logic [5:0]                      rnd_r, rnd_nxt;
  logic [1:0]                      oidx_r, oidx_nxt;
  md4_word_t                       step_word;

  assign step_word = md4_step(a_r, b_r, c_r, d_r, head.words[md4_word_idx(rnd_r)], rnd_r);

  assign out_chan.valid       = (state_r == B_OUT);
  assign out_chan.digest_word = cv_r[oidx_r];
  assign out_chan.word_index  = oidx_r;
  assign out_chan.last_word   = (oidx_r == LAST_IDX);

  // Load, run the rounds, fold into the chaining value, then emit
  always_comb begin
    state_nxt = state_r;
    cv_nxt    = cv_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    rnd_nxt   = rnd_r;
    oidx_nxt  = oidx_r;
    q_pop     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          a_nxt     = cv_r[0];
          b_nxt     = cv_r[1];
          c_nxt     = cv_r[2];
          d_nxt     = cv_r[3];
          rnd_nxt   = '0;
          state_nxt = B_RND;
        end
      end
      B_RND: begin
        a_nxt = d_r;
        d_nxt = c_r;
        c_nxt = b_r;
        b_nxt = step_word;
        if (rnd_r == LAST_RND) begin
          state_nxt = B_ADD;
        end else begin
          rnd_nxt = rnd_r + 6'd1;
        end
      end
      B_ADD: begin
        cv_nxt[0] = cv_r[0] + a_r;
        cv_nxt[1] = cv_r[1] + b_r;
        cv_nxt[2] = cv_r[2] + c_r;
        cv_nxt[3] = cv_r[3] + d_r;
        q_pop     = 1'b1;
        if (head.last_blk) begin
          oidx_nxt  = '0;
          state_nxt = B_OUT;
        end else begin
          state_nxt = B_IDLE;
        end
      end
      B_OUT: begin
        if (out_chan.ready) begin
          if (oidx_r == LAST_IDX) begin
            cv_nxt    = {IV3, IV2, IV1, IV0};
            state_nxt = B_IDLE;
          end else begin
            oidx_nxt = oidx_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cv_r    <= {IV3, IV2, IV1, IV0};
      rnd_r   <= '0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cv_r    <= cv_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  // Working words need no reset
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
  end

  a_cv_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.last_word)
      |=> (cv_r[0] == IV0 && cv_r[3] == IV3 && state_r == B_IDLE))
    else $error("chaining value not restored after digest");

  a_rnd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RND) |-> (rnd_r <= LAST_RND))
    else $error("round counter out of range");

endmodule

// ===== test/md4_message_digest_check.sv =====
// Checker for the MD4 digest block: predicts digest words from accepted bytes and compares.
`timescale 1ns / 1ps

module md4_message_digest_check import md4_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  md4_in_if    in_mon,
  md4_out_if   out_mon,
  output int   fail_count,
  output int   expected_left
);

  typedef struct packed {
    md4_word_t  digest_word;
    logic [1:0] word_index;
    logic       last_word;
  } digest_exp_t;

  digest_exp_t      digest_queue[$];
  md4_word_t        chain[CV_WORDS];
  md4_word_t        msg_words[NUM_WORDS];
  logic [CNT_W-1:0] byte_count;
  int               words_seen;

  // Load the initial chaining words
  function automatic void load_iv();
    chain[0] = IV0;
    chain[1] = IV1;
    chain[2] = IV2;
    chain[3] = IV3;
  endfunction

  // Place one byte into its little-endian lane; lane 0 clears the word
  function automatic void put_byte(input logic [5:0] pos, input logic [7:0] v);
    if (pos[1:0] == 2'd0)
      msg_words[pos[5:2]] = {24'd0, v};
    else
      msg_words[pos[5:2]] = msg_words[pos[5:2]] | (md4_word_t'(v) << (8 * pos[1:0]));
  endfunction

  // Fold the gathered block into the chaining words: three rounds of sixteen steps
  function automatic void fold_block();
    md4_word_t a, b, c, d, f, w, t;
    int        i, j, sel, s;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (i = 0; i < 48; i++) begin
      j = i % 16;
      if (i < 16) begin
        f = (b & c) | (~b & d);
        w = msg_words[j];
        case (j % 4)
          0:       s = 3;
          1:       s = 7;
          2:       s = 11;
          default: s = 19;
        endcase
      end else if (i < 32) begin
        f = (b & c) | (b & d) | (c & d);
        sel = (j % 4) * 4 + j / 4;
        w = msg_words[sel] + K2;
        case (j % 4)
          0:       s = 3;
          1:       s = 5;
          2:       s = 9;
          default: s = 13;
        endcase
      end else begin
        f = b ^ c ^ d;
        // word order of the last round is the bit-reversed step index
        sel = ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
        w = msg_words[sel] + K3;
        case (j % 4)
          0:       s = 3;
          1:       s = 9;
          2:       s = 11;
          default: s = 15;
        endcase
      end
      t = a + f + w;
      t = (t << s) | (t >> (32 - s));
      a = d;
      d = c;
      c = b;
      b = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input md4_word_t got, input md4_word_t want);
    $display("[%0t] digest word %0d %s: got %h, want %h", $time, words_seen, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [5:0]  pos;
    logic [63:0] bit_len;
    digest_exp_t want;
    int          k;
    if (!rst_n) begin
      load_iv();
      byte_count = '0;
      digest_queue.delete();
      words_seen = 0;
      fail_count = 0;
      expected_left <= 0;
    end else begin
      // Absorb an accepted word
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.byte_present) begin
          pos = byte_count[5:0];
          put_byte(pos, in_mon.data_byte);
          byte_count = byte_count + 1'b1;
          if (pos == LAST_POS)
            fold_block();
        end
        // Pad, append the bit length, and queue the four digest words
        if (in_mon.last_byte) begin
          pos = byte_count[5:0];
          put_byte(pos, PAD_BYTE);
          for (k = int'(pos[5:2]) + 1; k < NUM_WORDS; k++)
            msg_words[k] = '0;
          if (pos >= 6'd56) begin
            fold_block();
            for (k = 0; k < 14; k++)
              msg_words[k] = '0;
          end
          bit_len = {byte_count, 3'b000};
          msg_words[14] = bit_len[31:0];
          msg_words[15] = bit_len[63:32];
          fold_block();
          for (k = 0; k < CV_WORDS; k++) begin
            want.digest_word = chain[k];
            want.word_index  = 2'(k);
            want.last_word   = (2'(k) == LAST_IDX);
            digest_queue.push_back(want);
          end
          load_iv();
          byte_count = '0;
        end
      end

      // Compare an accepted result word with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (digest_queue.size() == 0) begin
          report_mismatch("arrived with none pending", out_mon.digest_word, '0);
        end else begin
          want = digest_queue.pop_front();
          if (out_mon.digest_word !== want.digest_word)
            report_mismatch("digest_word", out_mon.digest_word, want.digest_word);
          if (out_mon.word_index !== want.word_index)
            report_mismatch("word_index", md4_word_t'(out_mon.word_index),
                            md4_word_t'(want.word_index));
          if (out_mon.last_word !== want.last_word)
            report_mismatch("last_word", md4_word_t'(out_mon.last_word),
                            md4_word_t'(want.last_word));
        end
        words_seen++;
      end
      expected_left <= digest_queue.size();
    end
  end

endmodule

// ===== test/md4_message_digest_test.sv =====
// Testbench top for the MD4 digest block: clock, reset, byte stimulus, result flow control.
`timescale 1ns / 1ps

module md4_message_digest_test;

  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 200;
  localparam int BYTE_ITEMS   = 230;
  localparam int QUIET_ITEMS  = 190;
  localparam int MIN_MESSAGES = 14;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   expected_left;
  logic quiet, hold_req, hold_taken;
  logic tx_busy, rx_busy;
  int   rx_wait, idle_cycles;
  int   items_sent, messages_sent;

  md4_in_if  in_chan();
  md4_out_if out_chan();

  md4_message_digest dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  md4_message_digest_check digest_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Switch each side between busy and calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      tx_busy <= 1'b1;
      rx_busy <= 1'b1;
    end else begin
      if ($urandom_range(0, 47) == 0)
        tx_busy <= !tx_busy;
      if ($urandom_range(0, 47) == 0)
        rx_busy <= !rx_busy;
    end
  end

  // Drive result ready: one long hold on request, short random stalls otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rx_wait        <= 0;
      hold_taken     <= 1'b0;
    end else if (rx_wait != 0) begin
      out_chan.ready <= 1'b0;
      rx_wait        <= rx_wait - 1;
    end else if (hold_req && !hold_taken) begin
      out_chan.ready <= 1'b0;
      rx_wait        <= LONG_HOLD - 1;
      hold_taken     <= 1'b1;
    end else if (!quiet && rx_busy && $urandom_range(0, 4) == 0) begin
      out_chan.ready <= 1'b0;
      rx_wait        <= $urandom_range(0, 4);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("md4_message_digest: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one word, with an optional idle burst first; hold until accepted
  task automatic send_item(input logic [7:0] data, input logic present, input logic last);
    if (!quiet && tx_busy && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.data_byte    <= data;
    in_chan.byte_present <= present;
    in_chan.last_byte    <= last;
    @(posedge clk);
    while (in_chan.ready !== 1'b1)
      @(posedge clk);
    items_sent++;
  endtask

  // Send a message of random bytes, with stray idle words mixed in
  task automatic send_message(input int len, input logic end_apart);
    int k;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, !end_apart && k == len - 1);
    end
    if (end_apart || len == 0)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    messages_sent++;
  endtask

  // Drop valid and wait until every predicted digest word has come back
  task automatic drain_digests();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0)
      @(posedge clk);
  endtask

  initial begin
    int len;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.data_byte    <= '0;
    in_chan.byte_present <= 1'b0;
    in_chan.last_byte    <= 1'b0;
    quiet                <= 1'b0;
    hold_req             <= 1'b0;
    items_sent    = 0;
    messages_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty message, then idle words that must change nothing
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    // Single byte carrying the end, and single byte with the end apart
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
    // "abc"
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // Idle word inside a message
    send_item(8'h5a, 1'b1, 1'b0);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'h3c, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);

    // Random messages: mostly short, some around the padding and block edges
    while (items_sent < BYTE_ITEMS || messages_sent < MIN_MESSAGES) begin
      if (messages_sent >= 2 && messages_sent <= 5) begin
        len = $urandom_range(0, 3);
      end else if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 8))
          0:       len = 55;
          1:       len = 56;
          2:       len = 57;
          3:       len = 63;
          4:       len = 64;
          5:       len = 65;
          6:       len = 119;
          7:       len = 120;
          default: len = 128;
        endcase
      end else begin
        len = $urandom_range(0, 12);
      end
      // Keep the run near its word budget
      if (len > BYTE_ITEMS - items_sent)
        len = (items_sent < BYTE_ITEMS) ? BYTE_ITEMS - items_sent : 0;
      send_message(len, 1'($urandom_range(0, 1)));

      // Stall the result side for a long stretch so the input backs up
      if (messages_sent == 2)
        hold_req <= 1'b1;
      // Let the block empty out once mid-run
      if (messages_sent == 7)
        drain_digests();
      if (items_sent >= QUIET_ITEMS)
        quiet <= 1'b1;
    end

    drain_digests();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("md4_message_digest: match");
    else
      $display("md4_message_digest: mismatch");
    $finish;
  end

endmodule
